### rtl/core/hrdp_pkg.sv
package hrdp_pkg;

  localparam int unsigned SaveDepth       = 4;
  localparam int unsigned CollectionDepth = 8;
  localparam int unsigned MaxUsages       = 16;
  localparam int unsigned MaxSlots        = 64;

  localparam int unsigned SaveW    = $clog2(SaveDepth + 1);
  localparam int unsigned CollW    = $clog2(CollectionDepth + 1);
  localparam int unsigned UsageW   = $clog2(MaxUsages + 1);
  localparam int unsigned SlotW    = $clog2(MaxSlots + 1);
  localparam int unsigned UIdxW    = (MaxUsages > 1) ? $clog2(MaxUsages) : 1;
  localparam int unsigned SaveIdxW = (SaveDepth > 1) ? $clog2(SaveDepth) : 1;
  localparam int unsigned CollIdxW = (CollectionDepth > 1) ? $clog2(CollectionDepth) : 1;

  localparam int unsigned OffDepth = 768;
  localparam int unsigned OffAddrW = $clog2(OffDepth);

  localparam logic [7:0] LongPrefix = 8'hFE;

  localparam logic [1:0] TypeMain   = 2'd0;
  localparam logic [1:0] TypeGlobal = 2'd1;
  localparam logic [1:0] TypeLocal  = 2'd2;

  localparam logic [3:0] TagPage    = 4'h0;
  localparam logic [3:0] TagLmin    = 4'h1;
  localparam logic [3:0] TagLmax    = 4'h2;
  localparam logic [3:0] TagSize    = 4'h7;
  localparam logic [3:0] TagId      = 4'h8;
  localparam logic [3:0] TagCount   = 4'h9;
  localparam logic [3:0] TagPush    = 4'hA;
  localparam logic [3:0] TagPop     = 4'hB;
  localparam logic [3:0] TagUsage   = 4'h0;
  localparam logic [3:0] TagUmin    = 4'h1;
  localparam logic [3:0] TagUmax    = 4'h2;
  localparam logic [3:0] TagInput   = 4'h8;
  localparam logic [3:0] TagOutput  = 4'h9;
  localparam logic [3:0] TagFeature = 4'hB;
  localparam logic [3:0] TagColl    = 4'hA;
  localparam logic [3:0] TagEndColl = 4'hC;

  localparam logic [1:0] KindInput   = 2'd1;
  localparam logic [1:0] KindOutput  = 2'd2;
  localparam logic [1:0] KindFeature = 2'd3;

  localparam logic [1:0] StatKept  = 2'd0;
  localparam logic [1:0] StatConst = 2'd1;
  localparam logic [1:0] StatZero  = 2'd2;

  typedef struct packed {
    logic [15:0] page;
    logic [7:0]  id;
    logic [15:0] size;
    logic [15:0] count;
    logic [31:0] lmin;
    logic [31:0] lmax;
  } glob_t;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       first_of_descriptor;
    logic       last_of_descriptor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         report_kind;
    logic [7:0]         report_number;
    logic [15:0]        page_num;
    logic [15:0]        usage_code;
    logic [15:0]        bit_position;
    logic [15:0]        bit_width;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [15:0]        parent_usage;
    logic [1:0]         slot_status;
    logic               last_in_run;
  } out_item_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [31:0] sext(input logic [31:0] v, input logic [2:0] sz);
    logic [31:0] r;
    case (sz)
      3'd1:    r = {{24{v[7]}}, v[7:0]};
      3'd2:    r = {{16{v[15]}}, v[15:0]};
      3'd4:    r = v;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/hrdp_if.sv
interface hrdp_in_if;
  import hrdp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hrdp_out_if;
  import hrdp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/hid_report_descriptor_parser_core.sv
// HID report descriptor parser. Takes one descriptor byte per input item and
// emits one record per report slot of every Input, Output or Feature item.
// A byte that completes no main item is accepted and decoded. A byte that
// completes a main item is accepted, decoded, then passes offset table read,
// usage fill, the emission of its records (up to 64) and offset write-back;
// emission waits while the receiver stalls, since a record waits in the output
// register and no byte is accepted until the last record has left. After reset,
// and after accepting a byte flagged first_of_descriptor, the 768-entry offset
// table is cleared by a pass during which no byte is accepted; the flagged byte
// is decoded right after that pass. Global, usage and collection stacks live in
// registers; the offset table lives in a synchronous RAM.
module hid_report_descriptor_parser_core (
  input  logic clk_i,
  input  logic rst_ni,
  hrdp_in_if.sink    in_if,
  hrdp_out_if.source out_if
);
  import hrdp_pkg::*;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StByte  = 7'b0000100,
    StRead  = 7'b0001000,
    StFill  = 7'b0010000,
    StEmit  = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [OffAddrW-1:0] clr_q;
  in_item_t            in_q;

  logic        busy_q;
  logic [7:0]  prefix_q;
  logic [2:0]  need_q, got_q;
  logic [31:0] data_q;
  logic        long_wait_q;
  logic [8:0]  skip_q;

  glob_t             gs_q;
  glob_t             saved_q [SaveDepth];
  logic [SaveW-1:0]  saved_n_q;
  logic [15:0]       ul_q [MaxUsages];
  logic [UsageW-1:0] un_q;
  logic [15:0]       pl_q [MaxUsages];
  logic [UsageW-1:0] pn_q;
  logic [15:0]       rmin_q, rmax_q;
  logic [15:0]       coll_q [CollectionDepth];
  logic [CollW-1:0]  coll_n_q;

  // main item context
  logic [1:0]        kind_q;
  logic              cst_q;
  logic [15:0]       base_q;
  logic [15:0]       pos_q;
  logic [SlotW-1:0]  slot_q, slots_q;
  logic [OffAddrW-1:0] idx_q;

  logic      ovalid_q;
  out_item_t opay_q;
  logic      emit_go;

  logic                ram_we;
  logic [OffAddrW-1:0] ram_wa, ram_ra;
  logic [15:0]         ram_wd, ram_rd;

  hrdp_ram #(.Width(16), .Depth(OffDepth)) u_off (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  wire in_fire = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle) && !ovalid_q;
  assign out_if.valid = ovalid_q;
  assign out_if.payload = opay_q;
  assign emit_go = (state_q == StEmit) && (!ovalid_q || out_if.ready);

  // decoded item at StByte
  logic [7:0]  b;
  logic        run;
  logic [7:0]  rp;
  logic [31:0] rv;
  logic [2:0]  rs;
  logic [1:0]  rtype;
  logic [3:0]  rtag;
  logic        is_main;
  logic [31:0] nd;
  always_comb begin
    b = in_q.desc_byte;
    run = 1'b0; rp = b; rv = '0; rs = '0;
    nd = data_q | ({24'd0, b} << {got_q, 3'b000});
    if (skip_q != '0 || long_wait_q) begin
      run = 1'b0;
    end else if (busy_q) begin
      run = (got_q + 3'd1) >= need_q;
      rp = prefix_q; rv = nd; rs = need_q;
    end else if (b != LongPrefix) begin
      run = (b[1:0] == 2'd0);
    end
    rtype = rp[3:2];
    rtag  = rp[7:4];
    is_main = run && rtype == TypeMain &&
              (rtag == TagInput || rtag == TagOutput || rtag == TagFeature);
  end

  logic [UIdxW-1:0] slot_idx;
  assign slot_idx = slot_q[UIdxW-1:0];
  logic [15:0] cur_u;
  assign cur_u = ({{(32-SlotW){1'b0}}, slot_q} < {{(32-UsageW){1'b0}}, un_q})
                 ? ul_q[slot_idx] : 16'd0;

  always_comb begin
    state_d = state_q;
    ram_we = 1'b0; ram_wa = clr_q; ram_wd = '0; ram_ra = idx_q;
    case (state_q)
      StClear: begin
        ram_we = 1'b1;
        if (clr_q == OffAddrW'(OffDepth - 1)) begin
          state_d = in_q.first_of_descriptor ? StByte : StIdle;
        end
      end
      StIdle:  if (in_fire) state_d = in_if.payload.first_of_descriptor ? StClear : StByte;
      StByte:  state_d = is_main ? StRead : StIdle;
      StRead:  state_d = StFill;
      StFill:  state_d = (slots_q == '0) ? StDone : StEmit;
      StEmit:  if (emit_go) begin
        if (slot_q + SlotW'(1) >= slots_q) state_d = StDone;
      end
      StDone: begin
        ram_we = 1'b1; ram_wa = idx_q;
        ram_wd = base_q + 16'(gs_q.count * gs_q.size);
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (emit_go) begin
      ovalid_q <= 1'b1;
    end else if (out_if.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      busy_q <= 1'b0; long_wait_q <= 1'b0; skip_q <= '0;
      saved_n_q <= '0; un_q <= '0; pn_q <= '0; coll_n_q <= '0;
      gs_q <= '0; rmin_q <= '0; rmax_q <= '0;
      in_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StClear: clr_q <= clr_q + OffAddrW'(1);
        StIdle: if (in_fire) begin
          in_q <= in_if.payload;
          clr_q <= '0;
          if (in_if.payload.first_of_descriptor) begin
            busy_q <= 1'b0; long_wait_q <= 1'b0; skip_q <= '0;
            gs_q <= '0; saved_n_q <= '0; un_q <= '0; pn_q <= '0;
            rmin_q <= '0; rmax_q <= '0; coll_n_q <= '0;
          end
        end
        StByte: begin
          // drop an unfinished item or long item on the last byte
          if (skip_q != '0) begin
            skip_q <= in_q.last_of_descriptor ? 9'd0 : skip_q - 9'd1;
          end else if (long_wait_q) begin
            long_wait_q <= 1'b0;
            skip_q <= in_q.last_of_descriptor ? 9'd0 : {1'b0, b} + 9'd1;
          end else if (busy_q) begin
            data_q <= nd; got_q <= got_q + 3'd1;
            if (run || in_q.last_of_descriptor) busy_q <= 1'b0;
          end else if (b == LongPrefix) begin
            long_wait_q <= !in_q.last_of_descriptor;
          end else begin
            prefix_q <= b; got_q <= '0; data_q <= '0;
            need_q <= (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
            busy_q <= (b[1:0] != 2'd0) && !in_q.last_of_descriptor;
          end
          if (run) begin
            case (rtype)
              TypeGlobal: begin
                case (rtag)
                  TagPage:  gs_q.page <= rv[15:0];
                  TagLmin:  gs_q.lmin <= sext(rv, rs);
                  TagLmax:  gs_q.lmax <= sext(rv, rs);
                  TagSize:  gs_q.size <= sat16(rv);
                  TagId:    gs_q.id <= rv[7:0];
                  TagCount: gs_q.count <= sat16(rv);
                  TagPush: if (saved_n_q < SaveW'(SaveDepth)) begin
                    saved_q[saved_n_q[SaveIdxW-1:0]] <= gs_q;
                    saved_n_q <= saved_n_q + SaveW'(1);
                  end
                  TagPop: if (saved_n_q != '0) begin
                    gs_q <= saved_q[SaveIdxW'(saved_n_q - SaveW'(1))];
                    saved_n_q <= saved_n_q - SaveW'(1);
                  end
                  default: ;
                endcase
              end
              TypeLocal: begin
                case (rtag)
                  TagUsage: begin
                    if (rs == 3'd4) gs_q.page <= rv[31:16];
                    if (un_q < UsageW'(MaxUsages)) begin
                      ul_q[un_q[UIdxW-1:0]] <= rv[15:0];
                      un_q <= un_q + UsageW'(1);
                    end
                  end
                  TagUmin: rmin_q <= rv[15:0];
                  TagUmax: rmax_q <= rv[15:0];
                  default: ;
                endcase
              end
              TypeMain: begin
                case (rtag)
                  TagColl: begin
                    if (coll_n_q < CollW'(CollectionDepth)) begin
                      coll_q[coll_n_q[CollIdxW-1:0]]
                        <= (un_q != '0) ? ul_q[UIdxW'(un_q - UsageW'(1))] : 16'd0;
                      coll_n_q <= coll_n_q + CollW'(1);
                    end
                    un_q <= '0; pn_q <= '0; rmin_q <= '0; rmax_q <= '0;
                  end
                  TagEndColl: if (coll_n_q != '0) coll_n_q <= coll_n_q - CollW'(1);
                  TagInput, TagOutput, TagFeature: begin
                    kind_q <= (rtag == TagInput) ? KindInput :
                              (rtag == TagOutput) ? KindOutput : KindFeature;
                    cst_q <= rv[0];
                    idx_q <= OffAddrW'((rtag == TagInput) ? 0 : (rtag == TagOutput) ? 256 : 512)
                             + OffAddrW'(gs_q.id);
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        StRead: begin
          // expand the usage range into the list lanes, bounded by count and list size
          if (un_q == '0 && rmax_q != '0 && rmin_q <= rmax_q) begin
            for (int i = 0; i < MaxUsages; i++) begin
              ul_q[i] <= rmin_q + 16'(i);
            end
            begin
              logic [16:0] span;
              logic [16:0] lim;
              span = {1'b0, rmax_q} - {1'b0, rmin_q} + 17'd1;
              lim = (gs_q.count < 16'(MaxUsages)) ? {1'b0, gs_q.count} : 17'(MaxUsages);
              un_q <= UsageW'((span < lim) ? span : lim);
            end
          end
          slots_q <= (gs_q.count < 16'(MaxSlots)) ? SlotW'(gs_q.count) : SlotW'(MaxSlots);
          slot_q <= '0;
        end
        StFill: begin
          base_q <= ram_rd;
          pos_q <= ram_rd;
          if (un_q == '0 && pn_q != '0 && !cst_q) begin
            for (int i = 0; i < MaxUsages; i++) ul_q[i] <= pl_q[i];
            un_q <= pn_q;
          end
        end
        StEmit: if (emit_go) begin
          opay_q.report_kind   <= kind_q;
          opay_q.report_number <= gs_q.id;
          opay_q.page_num      <= gs_q.page;
          opay_q.usage_code    <= cur_u;
          opay_q.bit_position  <= pos_q;
          opay_q.bit_width     <= gs_q.size;
          opay_q.lower_bound   <= gs_q.lmin;
          opay_q.upper_bound   <= gs_q.lmax;
          opay_q.parent_usage  <= (coll_n_q != '0)
            ? coll_q[CollIdxW'(coll_n_q - CollW'(1))]
            : 16'd0;
          opay_q.slot_status   <= cst_q ? StatConst : (cur_u == '0 ? StatZero : StatKept);
          opay_q.last_in_run   <= (slot_q + SlotW'(1) >= slots_q);
          pos_q <= pos_q + gs_q.size;
          slot_q <= slot_q + SlotW'(1);
        end
        StDone: begin
          for (int i = 0; i < MaxUsages; i++) pl_q[i] <= ul_q[i];
          pn_q <= un_q; un_q <= '0; rmin_q <= '0; rmax_q <= '0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready) else $error("item taken while busy");
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == StEmit) else $error("record outside emit");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saved_n_q <= SaveW'(SaveDepth) && coll_n_q <= CollW'(CollectionDepth))
    else $error("stack overflow");
`endif
endmodule

### rtl/core/hrdp_ram.sv
module hrdp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### bench/hrdp_checker.sv
module hrdp_checker (
  input  logic clk_i,
  input  logic rst_ni,
  hrdp_in_if   in_mon,
  hrdp_out_if  out_mon,
  output int   fails_o,
  output int   pending_o,
  output int   records_o,
  output int   report_items_o
);
  import hrdp_pkg::*;

  // parser state
  logic        asm_busy;
  logic [7:0]  asm_prefix;
  int          asm_need;
  int          asm_got;
  logic [31:0] asm_data;
  logic        long_wait;
  int          skip_left;

  glob_t       gstate;
  glob_t       saved [SaveDepth];
  int          saved_n;
  logic [15:0] usages [MaxUsages];
  int          usage_n;
  logic [15:0] last_usages [MaxUsages];
  int          prev_n;
  logic [15:0] range_lo, range_hi;
  logic [15:0] coll_usage [CollectionDepth];
  int          coll_n;
  logic [15:0] offsets [OffDepth];

  out_item_t   expected_records [$];

  task automatic clear_parser();
    asm_busy = 0; asm_prefix = '0; asm_need = 0; asm_got = 0; asm_data = '0;
    long_wait = 0; skip_left = 0;
    gstate = '0; saved_n = 0; usage_n = 0; prev_n = 0;
    range_lo = '0; range_hi = '0; coll_n = 0;
    foreach (usages[i]) begin
      usages[i] = '0;
      last_usages[i] = '0;
    end
    foreach (offsets[i]) offsets[i] = '0;
  endtask

  function automatic logic [31:0] widen_signed(logic [31:0] v, int sz);
    case (sz)
      1: return {{24{v[7]}}, v[7:0]};
      2: return {{16{v[15]}}, v[15:0]};
      4: return v;
      default: return '0;
    endcase
  endfunction

  function automatic logic [15:0] clamp16(logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic emit_report(logic [1:0] kind, logic [31:0] v);
    logic        is_const;
    int          idx;
    logic [15:0] base;
    logic [15:0] parent;
    int          slots;
    int          u;
    out_item_t   rec;
    is_const = v[0];
    idx = (int'(kind) - 1) * 256 + int'(gstate.id);
    base = offsets[idx];
    parent = coll_n != 0 ? coll_usage[coll_n-1] : 16'h0;
    report_items_o++;
    if (usage_n == 0 && range_hi > 0 && range_lo <= range_hi) begin
      for (u = range_lo; u <= range_hi && usage_n < int'(gstate.count) &&
           usage_n < MaxUsages; u++) begin
        usages[usage_n] = u[15:0];
        usage_n++;
      end
    end
    if (usage_n == 0 && prev_n != 0 && !is_const) begin
      usages = last_usages;
      usage_n = prev_n;
    end
    slots = gstate.count < MaxSlots ? int'(gstate.count) : MaxSlots;
    for (int i = 0; i < slots; i++) begin
      rec.report_kind   = kind;
      rec.report_number = gstate.id;
      rec.page_num      = gstate.page;
      rec.usage_code    = i < usage_n ? usages[i] : 16'h0;
      rec.bit_position  = 16'(32'(base) + i * 32'(gstate.size));
      rec.bit_width     = gstate.size;
      rec.lower_bound   = gstate.lmin;
      rec.upper_bound   = gstate.lmax;
      rec.parent_usage  = parent;
      rec.slot_status   = is_const ? StatConst :
                          (rec.usage_code == 0 ? StatZero : StatKept);
      rec.last_in_run   = (i + 1 == slots);
      expected_records.insert(expected_records.size(), rec);
    end
    offsets[idx] = 16'(32'(base) + 32'(gstate.count) * 32'(gstate.size));
    last_usages = usages;
    prev_n = usage_n;
    usage_n = 0;
    range_lo = '0;
    range_hi = '0;
  endtask

  task automatic apply_item(logic [7:0] prefix, logic [31:0] v, int sz);
    logic [1:0] kind_t;
    logic [3:0] tag;
    kind_t = prefix[3:2];
    tag = prefix[7:4];
    if (kind_t == TypeGlobal) begin
      case (tag)
        TagPage:  gstate.page = v[15:0];
        TagLmin:  gstate.lmin = widen_signed(v, sz);
        TagLmax:  gstate.lmax = widen_signed(v, sz);
        TagSize:  gstate.size = clamp16(v);
        TagId:    gstate.id = v[7:0];
        TagCount: gstate.count = clamp16(v);
        TagPush:  if (saved_n < SaveDepth) begin
          saved[saved_n] = gstate;
          saved_n++;
        end
        TagPop:   if (saved_n != 0) begin
          saved_n--;
          gstate = saved[saved_n];
        end
        default: ;
      endcase
    end else if (kind_t == TypeLocal) begin
      if (tag == TagUsage) begin
        if (sz == 4) gstate.page = v[31:16];
        if (usage_n < MaxUsages) begin
          usages[usage_n] = v[15:0];
          usage_n++;
        end
      end else if (tag == TagUmin) begin
        range_lo = v[15:0];
      end else if (tag == TagUmax) begin
        range_hi = v[15:0];
      end
    end else if (kind_t == TypeMain) begin
      if (tag == TagColl) begin
        if (coll_n < CollectionDepth) begin
          coll_usage[coll_n] = usage_n != 0 ? usages[usage_n-1] : 16'h0;
          coll_n++;
        end
        usage_n = 0;
        prev_n = 0;
        range_lo = '0;
        range_hi = '0;
      end else if (tag == TagEndColl) begin
        if (coll_n != 0) coll_n--;
      end else if (tag == TagInput) begin
        emit_report(KindInput, v);
      end else if (tag == TagOutput) begin
        emit_report(KindOutput, v);
      end else if (tag == TagFeature) begin
        emit_report(KindFeature, v);
      end
    end
  endtask

  task automatic parse_byte(in_item_t it);
    logic [7:0] b;
    b = it.desc_byte;
    if (it.first_of_descriptor) clear_parser();
    if (skip_left != 0) begin
      skip_left--;
    end else if (long_wait) begin
      long_wait = 0;
      skip_left = int'(b) + 1;
    end else if (asm_busy) begin
      asm_data = asm_data | (32'(b) << (8 * asm_got));
      asm_got++;
      if (asm_got >= asm_need) begin
        asm_busy = 0;
        apply_item(asm_prefix, asm_data, asm_need);
      end
    end else if (b == LongPrefix) begin
      long_wait = 1;
    end else begin
      asm_prefix = b;
      asm_need = b[1:0] == 2'd3 ? 4 : int'(b[1:0]);
      asm_got = 0;
      asm_data = '0;
      if (asm_need == 0) apply_item(b, '0, 0);
      else asm_busy = 1;
    end
    if (it.last_of_descriptor) begin
      asm_busy = 0;
      long_wait = 0;
      skip_left = 0;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      clear_parser();
      expected_records.delete();
      fails_o = 0;
      records_o = 0;
      report_items_o = 0;
    end else begin
      // compare first: a record at this edge cannot come from the byte taken now
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        records_o++;
        if (expected_records.size() == 0) begin
          $display("%0t unexpected record: actual %0h", $time, got);
          fails_o++;
        end else begin
          want = expected_records.pop_front();
          check_field("report_kind", want.report_kind, got.report_kind);
          check_field("report_number", want.report_number, got.report_number);
          check_field("page_num", want.page_num, got.page_num);
          check_field("usage_code", want.usage_code, got.usage_code);
          check_field("bit_position", want.bit_position, got.bit_position);
          check_field("bit_width", want.bit_width, got.bit_width);
          check_field("lower_bound", want.lower_bound, got.lower_bound);
          check_field("upper_bound", want.upper_bound, got.upper_bound);
          check_field("parent_usage", want.parent_usage, got.parent_usage);
          check_field("slot_status", want.slot_status, got.slot_status);
          check_field("last_in_run", want.last_in_run, got.last_in_run);
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.payload);
    end
    pending_o = expected_records.size();
  end

endmodule

### bench/testbench.sv
module testbench;
  import hrdp_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fails, pending, records, report_items;
  int   bytes_sent, descriptors;
  logic no_gaps;
  logic [7:0] desc_q [$];

  hrdp_in_if  in_if ();
  hrdp_out_if out_if ();

  hid_report_descriptor_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  hrdp_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fails_o        (fails),
    .pending_o      (pending),
    .records_o      (records),
    .report_items_o (report_items)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off once records flow
  initial begin
    int   got;
    logic held;
    int   g;
    got = 0;
    held = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) got++;
      if (!held && got >= 40) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // idle-cycle watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic put_byte(logic [7:0] b, logic first, logic last);
    int g;
    g = no_gaps ? 0 : pick_gap();
    if (g != 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{desc_byte: b, first_of_descriptor: first,
                       last_of_descriptor: last};
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_descriptor();
    int n;
    n = desc_q.size();
    descriptors++;
    for (int i = 0; i < n; i++) put_byte(desc_q[i], i == 0, i == n - 1);
    desc_q.delete();
  endtask

  task automatic append_byte(logic [7:0] x);
    desc_q.insert(desc_q.size(), x);
  endtask

  task automatic add_short(logic [5:0] head, int code, logic [31:0] v);
    int nb;
    nb = code == 3 ? 4 : code;
    append_byte({head, code[1:0]});
    for (int i = 0; i < nb; i++) append_byte(v[8*i +: 8]);
  endtask

  function automatic logic [5:0] head_of(logic [3:0] tag, logic [1:0] kind_t);
    return {tag, kind_t};
  endfunction

  task automatic add_random_item();
    int          r, code;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    code = $urandom_range(1, 3);
    v = $urandom;
    if (r < 6)       add_short(head_of(TagPage, TypeGlobal), 1, v);
    else if (r < 14) add_short(head_of($urandom_range(0, 1) ? TagLmin : TagLmax,
                                       TypeGlobal), code, v);
    else if (r < 22) begin
      if ($urandom_range(0, 19) == 0) add_short(head_of(TagSize, TypeGlobal), code, v);
      else add_short(head_of(TagSize, TypeGlobal), 1, $urandom_range(1, 16));
    end else if (r < 32) begin
      if ($urandom_range(0, 24) == 0) add_short(head_of(TagCount, TypeGlobal), code, v);
      else add_short(head_of(TagCount, TypeGlobal), 1, $urandom_range(0, 12));
    end else if (r < 36) add_short(head_of(TagId, TypeGlobal), 1, $urandom_range(0, 3));
    else if (r < 42) add_short(head_of($urandom_range(0, 1) ? TagPush : TagPop,
                                       TypeGlobal), 0, 0);
    else if (r < 54) add_short(head_of(TagUsage, TypeLocal), code,
                               $urandom_range(0, 3) == 0 ? 32'h0 : v);
    else if (r < 62) add_short(head_of($urandom_range(0, 1) ? TagUmin : TagUmax,
                                       TypeLocal), 1, $urandom_range(0, 24));
    else if (r < 70) begin
      if ($urandom_range(0, 1)) add_short(head_of(TagColl, TypeMain), 1, v);
      else add_short(head_of(TagEndColl, TypeMain), 0, 0);
    end else if (r < 88) begin
      case ($urandom_range(0, 2))
        0:       add_short(head_of(TagInput, TypeMain), 1, v);
        1:       add_short(head_of(TagOutput, TypeMain), 1, v);
        default: add_short(head_of(TagFeature, TypeMain), $urandom_range(0, 2), v);
      endcase
    end else if (r < 93) begin
      append_byte(LongPrefix);
      r = $urandom_range(0, 3);
      append_byte(r[7:0]);
      append_byte(8'($urandom_range(0, 255)));
      for (int i = 0; i < r; i++) append_byte(8'($urandom_range(0, 255)));
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target, n;
    no_gaps = 0;
    bytes_sent = 0;
    descriptors = 0;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: extremes of limits and size, 4-byte usage, range, reuse,
    // constant item, stack edge cases, long item, reserved type, cut item
    desc_q = '{8'h05, 8'h01, 8'h09, 8'h02, 8'hA1, 8'h01,
               8'h17, 8'h00, 8'h00, 8'h00, 8'h80,
               8'h27, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
               8'h77, 8'hFF, 8'hFF, 8'h01, 8'h00,
               8'h95, 8'h03,
               8'h0B, 8'h01, 8'h00, 8'h0C, 8'h00,
               8'h81, 8'h02,
               8'h75, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h91, 8'h02,
               8'hB1, 8'h01, 8'hA4, 8'hA4, 8'hA4, 8'hA4, 8'hA4,
               8'hB4, 8'hB4, 8'hB4, 8'hB4, 8'hB4, 8'hB4,
               8'hC0, 8'hC0, 8'h81, 8'h00,
               8'hFE, 8'h02, 8'h05, 8'hAA, 8'hBB, 8'hDC,
               8'h96, 8'hFF, 8'hFF, 8'h81, 8'h00,
               8'h27, 8'h01};
    send_descriptor();
    // let every record drain before the random part
    while (pending != 0) @(posedge clk_i);

    target = 320;
    while (bytes_sent < target) begin
      no_gaps = $urandom_range(0, 3) == 0;
      n = $urandom_range(8, 25);
      for (int i = 0; i < n; i++) add_random_item();
      if ($urandom_range(0, 2) == 0) append_byte({6'($urandom_range(0, 63)), 2'd3});
      send_descriptor();
    end
    no_gaps = 0;
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d bytes in %0d descriptors; %0d report items, %0d records checked",
             bytes_sent, descriptors, report_items, records);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d records missing", fails, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
